[rtl/cldr_pkg.sv]
// Shared types and constants for the circular list deque remove block.
package cldr_pkg;

    // Number of cells in the row and the width of one entry.
    localparam int DEPTH = 16;
    localparam int DATA_W = 32;

    // Occupancy must be able to hold DEPTH itself.
    localparam int OCC_W = $clog2(DEPTH + 1);

    // Widths of the result fields and the packed stream words.
    localparam int OP_W = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W = 5;
    localparam int IN_BITS = OP_W + DATA_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STATUS_W + DATA_W + COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Operation codes.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH     = 2'd0,
        OP_POP_HEAD = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_POP_TAIL = 2'd3
    } op_t;

    // Status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic              take_prev;  // shift toward the tail (push)
        logic              take_next;  // shift toward the head (pop head)
        logic              remove_go;  // close the gap at the first match
        logic [DATA_W-1:0] key;        // value to compare against
    } cell_ctrl_t;

endpackage

[rtl/cldr_cell.sv]
// One cell of the list: holds an entry, compares it and shifts with its neighbors.
module cldr_cell
(
    input  logic                          clk,
    input  cldr_pkg::cell_ctrl_t          ctrl,
    input  logic                          valid,
    input  logic                          valid_next,
    input  logic [cldr_pkg::DATA_W-1:0]   prev_data,
    input  logic [cldr_pkg::DATA_W-1:0]   next_data,
    input  logic                          found_in,
    output logic                          found_out,
    output logic [cldr_pkg::DATA_W-1:0]   data,
    output logic [cldr_pkg::DATA_W-1:0]   tail_data
);

    logic [cldr_pkg::DATA_W-1:0] data_reg;
    logic [cldr_pkg::DATA_W-1:0] data_next;
    logic                        match;

    // A match here or in any cell nearer the head passes on toward the tail.
    assign match     = valid && (data_reg == ctrl.key);
    assign found_out = found_in || match;

    // The last held cell offers its entry for a pop at the tail.
    assign tail_data = (valid && !valid_next) ? data_reg : '0;
    assign data      = data_reg;

    // Pick the neighbor to load from, if any.
    always_comb
    begin
        priority if (ctrl.take_prev)
        begin
            data_next = prev_data;
        end
        else if (ctrl.take_next || (ctrl.remove_go && found_out))
        begin
            data_next = next_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    // Entry storage; its contents are only read while the cell is valid.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

[rtl/circular_list_deque_remove_core.sv]
// Top level of the bounded list: row of cells, occupancy counter and result register.
// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while results are drained; every operation is done in a single pass of
// the cell row, where all cells compare and shift in parallel.
// Input is taken whenever the result register is empty or being drained.
// Reset (rst_n low, asynchronous) empties the list and drops any pending result;
// entry contents are not cleared and are never read before they are written.
module circular_list_deque_remove_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [1:0] operation, [33:2] value, [39:34] zero
    input  logic [cldr_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [1:0] status, [33:2] removed_value, [38:34] count, [39] zero
    output logic [cldr_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    localparam int D  = cldr_pkg::DEPTH;
    localparam int DW = cldr_pkg::DATA_W;
    localparam int OW = cldr_pkg::OCC_W;

    logic                      accept;
    cldr_pkg::op_t             op;
    logic [DW-1:0]             value;
    logic                      full;
    logic                      empty;
    cldr_pkg::cell_ctrl_t      ctrl;

    logic [OW-1:0]             occ_reg;
    logic [OW-1:0]             occ_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    cldr_pkg::status_t         out_status_reg;
    logic [DW-1:0]             out_removed_reg;
    logic [cldr_pkg::COUNT_W-1:0] out_count_reg;

    cldr_pkg::status_t         status;
    logic [DW-1:0]             removed;
    logic [OW+cldr_pkg::COUNT_W-1:0] occ_wide;

    logic [D-1:0]              valid;
    logic [D:0]                valid_ext;
    logic [D:0]                found;
    logic [DW-1:0]             cell_data [D];
    logic [DW-1:0]             cell_tail [D];
    logic [DW-1:0]             tail_value;

    // Handshake and field unpacking.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op       = cldr_pkg::op_t'(s_tdata[cldr_pkg::OP_W-1:0]);
    assign value    = s_tdata[cldr_pkg::OP_W +: DW];
    assign full     = (occ_reg == OW'(D));
    assign empty    = (occ_reg == '0);

    // Control broadcast to the row.
    always_comb
    begin
        ctrl.take_prev = accept && (op == cldr_pkg::OP_PUSH) && !full;
        ctrl.take_next = accept && (op == cldr_pkg::OP_POP_HEAD) && !empty;
        ctrl.remove_go = accept && (op == cldr_pkg::OP_REMOVE) && !empty;
        ctrl.key       = value;
    end

    // Cells below the occupancy hold entries.
    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            valid[i] = (occ_reg > OW'(i));
        end
        valid_ext = {1'b0, valid};
    end

    assign found[0] = 1'b0;

    // The row of cells, head at index zero.
    for (genvar g = 0; g < D; g++)
    begin : g_cell
        logic [DW-1:0] prev_d;
        logic [DW-1:0] next_d;

        if (g == 0)
        begin : g_head
            assign prev_d = value;
        end
        else
        begin : g_body
            assign prev_d = cell_data[g-1];
        end

        if (g == D - 1)
        begin : g_last
            assign next_d = '0;
        end
        else
        begin : g_inner
            assign next_d = cell_data[g+1];
        end

        cldr_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .valid      (valid[g]),
            .valid_next (valid_ext[g+1]),
            .prev_data  (prev_d),
            .next_data  (next_d),
            .found_in   (found[g]),
            .found_out  (found[g+1]),
            .data       (cell_data[g]),
            .tail_data  (cell_tail[g])
        );
    end

    // Only the tail cell offers a nonzero word, so an OR picks it out.
    always_comb
    begin
        tail_value = '0;
        for (int i = 0; i < D; i++)
        begin
            tail_value = tail_value | cell_tail[i];
        end
    end

    // Result and next occupancy for the operation at the input.
    always_comb
    begin
        status   = cldr_pkg::ST_OK;
        removed  = '0;
        occ_next = occ_reg;
        unique case (op)
            cldr_pkg::OP_PUSH:
            begin
                if (full)
                begin
                    status = cldr_pkg::ST_FULL;
                end
                else
                begin
                    occ_next = occ_reg + OW'(1);
                end
            end
            cldr_pkg::OP_POP_HEAD:
            begin
                if (empty)
                begin
                    status = cldr_pkg::ST_EMPTY;
                end
                else
                begin
                    removed  = cell_data[0];
                    occ_next = occ_reg - OW'(1);
                end
            end
            cldr_pkg::OP_REMOVE:
            begin
                if (empty)
                begin
                    status = cldr_pkg::ST_EMPTY;
                end
                else if (found[D])
                begin
                    removed  = value;
                    occ_next = occ_reg - OW'(1);
                end
                else
                begin
                    status = cldr_pkg::ST_NOTFOUND;
                end
            end
            cldr_pkg::OP_POP_TAIL:
            begin
                if (empty)
                begin
                    status = cldr_pkg::ST_EMPTY;
                end
                else
                begin
                    removed  = tail_value;
                    occ_next = occ_reg - OW'(1);
                end
            end
            default:
            begin
                status = cldr_pkg::ST_OK;
            end
        endcase
    end

    assign occ_wide = {{cldr_pkg::COUNT_W{1'b0}}, occ_next};

    // Output valid flag follows the handshake on both sides.
    always_comb
    begin
        priority if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                occ_reg <= occ_next;
            end
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_status_reg  <= status;
            out_removed_reg <= removed;
            out_count_reg   <= occ_wide[cldr_pkg::COUNT_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(cldr_pkg::OUT_TDATA_W - cldr_pkg::OUT_BITS){1'b0}},
                       out_count_reg, out_removed_reg, out_status_reg};

    // The list never holds more than the row has cells.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OW'(D))
        else $error("occupancy beyond depth");

    // A push that is taken into a list with room grows it by one.
    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == cldr_pkg::OP_PUSH && !full)
        |=> (occ_reg == $past(occ_reg) + OW'(1)))
        else $error("push did not grow the list");

    // An empty status always reports an empty list and nothing removed.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_status_reg == cldr_pkg::ST_EMPTY)
        |-> (out_count_reg == '0 && out_removed_reg == '0))
        else $error("empty status with nonzero result");

    // A taken input always leaves a result waiting in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("result missing after accepted word");

    // A failed operation leaves the occupancy alone.
    a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status != cldr_pkg::ST_OK) |=> $stable(occ_reg))
        else $error("failed operation changed occupancy");

endmodule

[tb/circular_list_deque_remove_core_tb.sv]
// Self-checking testbench for the bounded list block, with its own list model and scoreboard.
module circular_list_deque_remove_core_tb;

    // One expected result word, split into its fields.
    typedef struct {
        cldr_pkg::status_t                  status;
        logic [cldr_pkg::DATA_W-1:0]        removed;
        logic [cldr_pkg::COUNT_W-1:0]       count;
    } list_result_t;

    // Keeps a copy of the list, predicts the result of every accepted
    // input word and checks each result word against the oldest prediction.
    class list_scoreboard;
        logic [cldr_pkg::DATA_W-1:0] cells [cldr_pkg::DEPTH];
        int                          occupancy;
        list_result_t                expected_results [$];
        int                          mismatches;
        int                          results_seen;

        function new();
            occupancy = 0;
            mismatches = 0;
            results_seen = 0;
            foreach (cells[i])
                cells[i] = '0;
        endfunction

        // Apply one accepted operation to the list copy and queue its result.
        function void note_input(cldr_pkg::op_t op, logic [cldr_pkg::DATA_W-1:0] val);
            list_result_t res;
            int           hit;
            res.status = cldr_pkg::ST_OK;
            res.removed = '0;
            hit = -1;
            if (op == cldr_pkg::OP_PUSH)
            begin
                if (occupancy >= cldr_pkg::DEPTH)
                begin
                    res.status = cldr_pkg::ST_FULL;
                end
                else
                begin
                    for (int i = occupancy; i > 0; i--)
                        cells[i] = cells[i-1];
                    cells[0] = val;
                    occupancy++;
                end
            end
            else if (occupancy == 0)
            begin
                res.status = cldr_pkg::ST_EMPTY;
            end
            else if (op == cldr_pkg::OP_POP_TAIL)
            begin
                res.removed = cells[occupancy-1];
                occupancy--;
            end
            else
            begin
                // Pop head removes position zero; remove looks for the first match.
                if (op == cldr_pkg::OP_POP_HEAD)
                begin
                    hit = 0;
                end
                else
                begin
                    for (int i = 0; i < occupancy; i++)
                    begin
                        if (hit < 0 && cells[i] == val)
                            hit = i;
                    end
                end
                if (hit < 0)
                begin
                    res.status = cldr_pkg::ST_NOTFOUND;
                end
                else
                begin
                    res.removed = cells[hit];
                    for (int i = hit; i + 1 < occupancy; i++)
                        cells[i] = cells[i+1];
                    occupancy--;
                end
            end
            res.count = occupancy[cldr_pkg::COUNT_W-1:0];
            expected_results.push_back(res);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            mismatches++;
            $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
                     results_seen, what, got, want);
        endtask

        // Compare one accepted result word with the oldest prediction.
        task check_result(logic [cldr_pkg::OUT_TDATA_W-1:0] word);
            list_result_t                  want;
            logic [cldr_pkg::STATUS_W-1:0] got_status;
            logic [cldr_pkg::DATA_W-1:0]   got_removed;
            logic [cldr_pkg::COUNT_W-1:0]  got_count;
            results_seen++;
            got_status = word[cldr_pkg::STATUS_W-1:0];
            got_removed = word[cldr_pkg::STATUS_W +: cldr_pkg::DATA_W];
            got_count = word[cldr_pkg::STATUS_W+cldr_pkg::DATA_W +: cldr_pkg::COUNT_W];
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected word", 64'(word), 64'd0);
                return;
            end
            want = expected_results.pop_front();
            if (got_status !== want.status)
                report_mismatch("status", 64'(got_status), 64'(want.status));
            if (got_removed !== want.removed)
                report_mismatch("removed_value", 64'(got_removed), 64'(want.removed));
            if (got_count !== want.count)
                report_mismatch("count", 64'(got_count), 64'(want.count));
        endtask
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [cldr_pkg::IN_TDATA_W-1:0]   s_tdata = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [cldr_pkg::OUT_TDATA_W-1:0]  m_tdata;

    list_scoreboard sb;
    int             burst_left = 0;
    int             ready_left = 0;
    logic           ready_level = 1'b0;
    logic [cldr_pkg::DATA_W-1:0] value_pool [8] = '{32'h0000_0000, 32'h0000_0001,
                                                    32'hFFFF_FFFF, 32'h8000_0000,
                                                    32'h7FFF_FFFF, 32'h0000_0005,
                                                    32'h5555_5555, 32'hAAAA_AAAA};

    circular_list_deque_remove_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock with a period of 12.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Send one word, opening a new burst, mostly after a random gap, when the old one is used up.
    task send_item(input cldr_pkg::op_t op, input logic [cldr_pkg::DATA_W-1:0] val);
        int          gap;
        logic [63:0] noise;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 6);
                noise = {$urandom, $urandom};
                @(negedge clk);
                s_tvalid = 1'b0;
                s_tdata = noise[cldr_pkg::IN_TDATA_W-1:0];
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata = {{(cldr_pkg::IN_TDATA_W-cldr_pkg::IN_BITS){1'b0}}, val, op};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(op, val);
    endtask

    // Removes target a held value half the time; other values come from a small pool
    // of extreme and patterned values, so they repeat, or are fully random.
    function logic [cldr_pkg::DATA_W-1:0] pick_value(cldr_pkg::op_t op);
        int roll;
        roll = $urandom_range(0, 9);
        if (op == cldr_pkg::OP_REMOVE && sb.occupancy > 0 && roll < 5)
            return sb.cells[$urandom_range(0, sb.occupancy - 1)];
        if (roll < 8)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // The receiver alternates long ready stretches, short ready runs and stalls.
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    ready_level = 1'b1;
                    ready_left = $urandom_range(20, 60);
                end
                2, 3, 4, 5:
                begin
                    ready_level = 1'b1;
                    ready_left = $urandom_range(1, 6);
                end
                default:
                begin
                    ready_level = 1'b0;
                    ready_left = $urandom_range(1, 8);
                end
            endcase
        end
        ready_left--;
        m_tready = ready_level;
    end

    // Check every result word accepted by the receiver.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Main stimulus: directed corner cases, then random traffic in fill, drain and balanced phases.
    initial
    begin
        int            seg_left;
        int            push_bias;
        int            roll;
        cldr_pkg::op_t op;
        sb = new();
        seg_left = 0;
        push_bias = 50;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Every removal on an empty list.
        send_item(cldr_pkg::OP_POP_HEAD, 32'h0000_0000);
        send_item(cldr_pkg::OP_POP_TAIL, 32'hFFFF_FFFF);
        send_item(cldr_pkg::OP_REMOVE, 32'h0000_0000);
        // Removing the only entry leaves the list empty.
        send_item(cldr_pkg::OP_PUSH, 32'h8000_0000);
        send_item(cldr_pkg::OP_REMOVE, 32'h8000_0000);
        send_item(cldr_pkg::OP_PUSH, 32'h7FFF_FFFF);
        send_item(cldr_pkg::OP_PUSH, 32'hFFFF_FFFF);
        // A value that is not held is reported as not found.
        send_item(cldr_pkg::OP_REMOVE, 32'h0000_0000);
        send_item(cldr_pkg::OP_POP_TAIL, 32'h0000_0000);
        send_item(cldr_pkg::OP_POP_HEAD, 32'h0000_0000);
        // Fill the list with duplicates, push once more onto the full list,
        // then remove a duplicated value, which must take the one nearest the head.
        for (int i = 0; i < cldr_pkg::DEPTH; i++)
            send_item(cldr_pkg::OP_PUSH,
                      (i % 3 == 0) ? 32'h0000_0005 : 32'h1000_0000 + i);
        send_item(cldr_pkg::OP_PUSH, 32'hDEAD_BEEF);
        send_item(cldr_pkg::OP_REMOVE, 32'h0000_0005);

        for (int n = 0; n < 1450; n++)
        begin
            if (seg_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0: push_bias = 75;
                    1: push_bias = 25;
                    default: push_bias = 50;
                endcase
                seg_left = $urandom_range(20, 80);
            end
            seg_left--;
            roll = $urandom_range(0, 99);
            if (roll < push_bias)
            begin
                op = cldr_pkg::OP_PUSH;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: op = cldr_pkg::OP_POP_HEAD;
                    1: op = cldr_pkg::OP_POP_TAIL;
                    default: op = cldr_pkg::OP_REMOVE;
                endcase
            end
            send_item(op, pick_value(op));
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
rtl/cldr_pkg.sv
rtl/cldr_cell.sv
rtl/circular_list_deque_remove_core.sv
tb/circular_list_deque_remove_core_tb.sv
